// ----- src/spmv_pkg.sv -----
// ----------------------------------------------------------------------------
// spmv_pkg
// Shared types and constants for the sparse matrix-vector multiplier.
// ----------------------------------------------------------------------------
package spmv_pkg;

    localparam int MAX_DIM      = 64;
    localparam int MAX_NONZEROS = 1024;
    localparam int DIM_W        = 7;
    localparam int IDX_W        = 6;
    localparam int NZ_W         = 10;
    localparam int PTR_W        = 11;
    localparam int VAL_W        = 32;
    localparam int ACC_W        = 48;
    localparam int CFG_IDX_W    = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] REQ_LOAD_PTR = 2'd0;
    localparam logic [1:0] REQ_LOAD_NZ  = 2'd1;
    localparam logic [1:0] REQ_LOAD_X   = 2'd2;
    localparam logic [1:0] REQ_START    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STORAGE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION      = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CMD_PTR   = 2'd0,
        CMD_NZ    = 2'd1,
        CMD_X     = 2'd2,
        CMD_START = 2'd3
    } cmd_kind_t;

    // classified command handed from front to back
    typedef struct packed {
        cmd_kind_t          kind;
        logic [NZ_W-1:0]    position;
        logic [IDX_W-1:0]   minor_index;
        logic [VAL_W-1:0]   data_value;
        logic               mode;
        logic [DIM_W-1:0]   dim;
    } cmd_t;

endpackage

// ----- src/spmv_if.sv -----
// ----------------------------------------------------------------------------
// spmv_if
// Valid/ready channel interfaces: input items, results and configuration.
// ----------------------------------------------------------------------------
interface spmv_req_if;
    import spmv_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [NZ_W-1:0]    position;
    logic [IDX_W-1:0]   minor_index;
    logic signed [VAL_W-1:0] data_value;
    modport source (output valid, req_type, position, minor_index, data_value,
                    input ready);
    modport sink   (input valid, req_type, position, minor_index, data_value,
                    output ready);
endinterface

interface spmv_res_if;
    import spmv_pkg::*;
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   result_index;
    logic signed [ACC_W-1:0] result_value;
    logic               last_element;
    modport source (output valid, result_index, result_value, last_element,
                    input ready);
    modport sink   (input valid, result_index, result_value, last_element,
                    output ready);
endinterface

interface spmv_cfg_if;
    import spmv_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/spmv_front.sv -----
// ----------------------------------------------------------------------------
// spmv_front
// Configuration registers, item classification and the command queue.
// ----------------------------------------------------------------------------
module spmv_front
    import spmv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    spmv_req_if.sink  req,
    spmv_cfg_if.sink  cfg,
    output logic      cmd_valid,
    input  logic      cmd_ready,
    output cmd_t      cmd
);

    logic             fmt_reg;
    logic             trn_reg;
    logic [DIM_W-1:0] dim_reg;

    cmd_t             queue_reg [QUEUE_DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;
    cmd_t             in_cmd;
    logic [DIM_W-1:0] dim_eff;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= 1'b0;
            trn_reg <= 1'b0;
            dim_reg <= DIM_W'(MAX_DIM);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_STORAGE_FORMAT: fmt_reg <= cfg.data[0];
                CFG_TRANSPOSE_MODE: trn_reg <= cfg.data[0];
                CFG_DIMENSION:      dim_reg <= cfg.data[DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // clamp dimension into 1..MAX_DIM
    always_comb
    begin
        if (dim_reg == '0)
            dim_eff = DIM_W'(1);
        else if (dim_reg > DIM_W'(MAX_DIM))
            dim_eff = DIM_W'(MAX_DIM);
        else
            dim_eff = dim_reg;
    end

    always_comb
    begin
        in_cmd.kind        = cmd_kind_t'(req.req_type);
        in_cmd.position    = req.position;
        in_cmd.minor_index = req.minor_index;
        in_cmd.data_value  = req.data_value;
        in_cmd.mode        = fmt_reg ^ trn_reg;
        in_cmd.dim         = dim_eff;
    end

    assign req.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("command queue overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'(QUEUE_DEPTH)) |-> !req.ready)
        else $error("input taken while queue full");
    a_dim_range: assert property (@(posedge clk) disable iff (!rst_n)
        (dim_eff != '0) && (dim_eff <= DIM_W'(MAX_DIM)))
        else $error("effective dimension out of range");
`endif

endmodule

// ----- src/spmv_back.sv -----
// ----------------------------------------------------------------------------
// spmv_back
// Stores, multiply-accumulate sequencer and result emission.
// ----------------------------------------------------------------------------
module spmv_back
    import spmv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    spmv_res_if.source res
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_CLEAR = 8'b0000_0010,
        ST_PTR   = 8'b0000_0100,
        ST_RDNZ  = 8'b0000_1000,
        ST_RDX   = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    logic [PTR_W-1:0] ptr_mem   [MAX_DIM+1];
    logic [IDX_W-1:0] idx_mem   [MAX_NONZEROS];
    logic [VAL_W-1:0] val_mem   [MAX_NONZEROS];
    logic [VAL_W-1:0] x_mem     [MAX_DIM];
    logic [ACC_W-1:0] acc_mem   [MAX_DIM];

    state_t           state_reg;
    logic             mode_reg;
    logic [DIM_W-1:0] dim_reg;
    logic [DIM_W-1:0] j_reg;
    logic [PTR_W-1:0] k_reg, hi_reg;
    logic             ptr_phase_reg;
    logic [PTR_W-1:0] ptr_rd_reg;
    logic [IDX_W-1:0] idx_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [VAL_W-1:0] x_rd_reg;
    logic [ACC_W-1:0] acc_rd_reg;
    logic signed [63:0] prod_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             skip_reg;
    logic             out_valid_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic [ACC_W-1:0] out_val_reg;
    logic             out_last_reg;
    logic [DIM_W-1:0] emit_reg;
    logic             emit_rd_reg;

    logic [PTR_W-1:0]   ptr_addr;
    logic [PTR_W-1:0]   hi_clamp;
    logic [IDX_W-1:0]   x_addr;
    logic signed [48:0] sum;
    logic [ACC_W-1:0]   sat;
    logic               out_free;
    logic               emit_fire;

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign emit_fire = (state_reg == ST_EMIT) && emit_rd_reg && out_free;

    // stores: loads are written from the command, reads are registered
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            case (cmd.kind)
                CMD_PTR:
                    if (cmd.position <= NZ_W'(MAX_DIM))
                        ptr_mem[cmd.position[DIM_W-1:0]] <= cmd.data_value[PTR_W-1:0];
                CMD_NZ:
                begin
                    idx_mem[cmd.position] <= cmd.minor_index;
                    val_mem[cmd.position] <= cmd.data_value;
                end
                CMD_X:
                    if (cmd.position < NZ_W'(MAX_DIM))
                        x_mem[cmd.position[IDX_W-1:0]] <= cmd.data_value;
                default: ;
            endcase
        end
        ptr_rd_reg <= ptr_mem[ptr_addr[DIM_W-1:0]];
        idx_rd_reg <= idx_mem[k_reg[NZ_W-1:0]];
        val_rd_reg <= val_mem[k_reg[NZ_W-1:0]];
        x_rd_reg   <= x_mem[x_addr];
        acc_rd_reg <= acc_mem[(state_reg == ST_EMIT) ? emit_reg[IDX_W-1:0]
                                                     : slot_reg];
        if (state_reg == ST_CLEAR)
            acc_mem[j_reg[IDX_W-1:0]] <= '0;
        else if (state_reg == ST_ACC && !skip_reg)
            acc_mem[slot_reg] <= sat;
    end

    assign ptr_addr = PTR_W'(j_reg) + PTR_W'(ptr_phase_reg);
    assign x_addr   = mode_reg ? idx_rd_reg : j_reg[IDX_W-1:0];
    assign hi_clamp = (ptr_rd_reg > PTR_W'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS)
                                                          : ptr_rd_reg;
    assign sum      = 49'(signed'(acc_rd_reg)) + 49'(prod_reg >>> 16);
    always_comb
    begin
        if (sum > 49'(signed'(ACC_MAX)))
            sat = ACC_MAX;
        else if (sum < 49'(signed'(ACC_MIN)))
            sat = ACC_MIN;
        else
            sat = sum[ACC_W-1:0];
    end

    // ST_PTR: phase 0 issues ptr[j] read, phase 1 issues ptr[j+1] and latches lo,
    // phase 2 latches hi and decides; the line loop then walks k.
    logic [1:0] pstep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            j_reg         <= '0;
            pstep_reg     <= '0;
            ptr_phase_reg <= 1'b0;
            emit_reg      <= '0;
            emit_rd_reg   <= 1'b0;
        end
        else
        begin
            if (res.valid && res.ready && !emit_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (cmd_valid && cmd.kind == CMD_START)
                    begin
                        mode_reg  <= cmd.mode;
                        dim_reg   <= cmd.dim;
                        j_reg     <= '0;
                        state_reg <= ST_CLEAR;
                    end
                ST_CLEAR:
                    if (j_reg == DIM_W'(MAX_DIM - 1))
                    begin
                        j_reg         <= '0;
                        pstep_reg     <= '0;
                        ptr_phase_reg <= 1'b0;
                        state_reg     <= ST_PTR;
                    end
                    else
                        j_reg <= j_reg + 1'b1;
                ST_PTR:
                begin
                    if (j_reg == dim_reg)
                    begin
                        emit_reg    <= '0;
                        emit_rd_reg <= 1'b0;
                        state_reg   <= ST_EMIT;
                    end
                    else
                    case (pstep_reg)
                        2'd0:
                        begin
                            ptr_phase_reg <= 1'b1;
                            pstep_reg     <= 2'd1;
                        end
                        2'd1:
                        begin
                            k_reg     <= ptr_rd_reg;
                            pstep_reg <= 2'd2;
                        end
                        default:
                        begin
                            hi_reg    <= hi_clamp;
                            pstep_reg <= 2'd3;
                            if (k_reg < hi_clamp)
                                state_reg <= ST_RDNZ;
                            else
                            begin
                                j_reg         <= j_reg + 1'b1;
                                ptr_phase_reg <= 1'b0;
                                pstep_reg     <= 2'd0;
                            end
                        end
                    endcase
                end
                ST_RDNZ: state_reg <= ST_RDX;
                ST_RDX:
                begin
                    slot_reg  <= mode_reg ? j_reg[IDX_W-1:0] : idx_rd_reg;
                    skip_reg  <= (DIM_W'(idx_rd_reg) >= dim_reg);
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    prod_reg  <= signed'(val_rd_reg) * signed'(x_rd_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (k_reg + 1'b1 < hi_reg)
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RDNZ;
                    end
                    else
                    begin
                        j_reg         <= j_reg + 1'b1;
                        ptr_phase_reg <= 1'b0;
                        pstep_reg     <= 2'd0;
                        state_reg     <= ST_PTR;
                    end
                end
                ST_EMIT:
                    if (!emit_rd_reg)
                        emit_rd_reg <= 1'b1;
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_idx_reg   <= emit_reg[IDX_W-1:0];
                        out_val_reg   <= acc_rd_reg;
                        out_last_reg  <= (emit_reg + 1'b1 == dim_reg);
                        emit_rd_reg   <= 1'b0;
                        if (emit_reg + 1'b1 == dim_reg)
                            state_reg <= ST_IDLE;
                        else
                            emit_reg <= emit_reg + 1'b1;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.result_index = out_idx_reg;
    assign res.result_value = out_val_reg;
    assign res.last_element = out_last_reg;

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd_ready)
        else $error("command taken while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> res.valid && $stable(out_val_reg))
        else $error("stalled result lost");
`endif

endmodule

// ----- src/sparse_matrix_vector_multiply.sv -----
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply
// Compressed sparse matrix times dense vector, with optional transpose.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  req      | in  | req_type, position, minor_index, data_value
//  res      | out | result_index, result_value, last_element
//  cfg      | in  | index, data
//
//  Load items take one cycle each through a two-entry command queue while
//  it has room. A start clears the accumulators, reads each line's pointer
//  pair and steps each nonzero through the single multiply-accumulate
//  sequencer, then reads each y element out of the accumulator memory.
//  Reset is asynchronous; the stores hold no reset value. A stalled result
//  holds the sequencer; the queue keeps taking loads until it is full.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply
    import spmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spmv_req_if.sink    req,
    spmv_cfg_if.sink    cfg,
    spmv_res_if.source  res
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    spmv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    spmv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res       (res)
    );

endmodule
